// ----- hw/rtl/fms_pkg.sv -----
// Shared types and constants for the maximal free space manager.
// Used by the core, fms_rank, the checker and the testbench; no dependencies.
package fms_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 12;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DIST_W      = COORD_BITS + 3;
    localparam int VOL_W       = 3 * COORD_BITS;
    localparam int ENTRY_W     = 6 * COORD_BITS;
    localparam int IN_DATA_W   = ((9 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((6 * COORD_BITS + CNT_W + 7) / 8) * 8;
    localparam int PADDR_W     = 4;

    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0] ext;
        logic [2:0][COORD_BITS-1:0] org;
    } entry_t;

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE,
        S_P1_RD, S_P1_US, S_P1_REM,
        S_P2_RD, S_P2_US, S_P2_SPL,
        S_P4_IRD, S_P4_IUS, S_P4_JRD, S_P4_JUS,
        S_P5_RD, S_P5_US,
        S_BST_RD, S_BST_US, S_BST_W1, S_BST_W2,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/maximal_free_space_manager_core.sv -----
// Top level: sequencer over a ping-pong pair of entry tables and the ranking unit.
// Depends on fms_pkg, fms_ram and fms_rank.
// Steps: a clear item rewrites entry zero and ranks it; a place item runs remove, remainders,
//   split, containment, compact and rank.
// One item at a time: a new item is accepted only in the idle state.
// Reset: synchronous, active low; first cycle after reset writes entry zero (whole container).
module maximal_free_space_manager_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // space_x, space_y, space_z, space_len, space_wid, space_hgt,
    // block_len, block_wid, block_hgt, zero pad
    input  logic [fms_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // best_x, best_y, best_z, best_len, best_wid, best_hgt, entry_count, zero pad
    output logic [fms_pkg::OUT_DATA_W-1:0]    m_tdata,
    // found, overflow
    output logic [1:0]                        m_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fms_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CB    = fms_pkg::COORD_BITS;
    localparam int CNT_W = fms_pkg::CNT_W;
    localparam int IDX_W = fms_pkg::IDX_W;
    localparam int MAXE  = fms_pkg::MAX_ENTRIES;

    fms_pkg::state_t              state_reg, state_next;
    logic [2:0][CB-1:0]           cfg_reg;
    fms_pkg::entry_t              sp_reg, sp_next, ent_reg, ent_next;
    logic [2:0][CB-1:0]           bx_reg, bx_next;
    logic [CNT_W-1:0]             i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next, n_inc;
    logic [2:0]                   k_reg, k_next;
    logic                         cur_reg, cur_next, ovf_reg, ovf_next;
    logic [MAXE-1:0]              drop_reg, drop_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [fms_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]                   m_tuser_reg, m_tuser_next;

    fms_pkg::entry_t              rd0, rd1, rd_data, wr_data, put_val, dir_val, boot_ent;
    fms_pkg::entry_t              rem_val, piece_val, rank_best, best_out;
    logic [IDX_W-1:0]             rd_addr, wr_addr;
    logic                         wr_en, wr_bank, put_req, dir_wr, full;
    logic                         match, rem_ok, hit, piece_ok, strict, found;

    function automatic logic inside_of(fms_pkg::entry_t p, fms_pkg::entry_t q);
        logic r;
        r = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (p.org[a] < q.org[a]) r = 1'b0;
            if (({1'b0, p.org[a]} + {1'b0, p.ext[a]}) > ({1'b0, q.org[a]} + {1'b0, q.ext[a]}))
                r = 1'b0;
        end
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0] <= CB'(1024);
            cfg_reg[1] <= CB'(1024);
            cfg_reg[2] <= CB'(1024);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                fms_pkg::REG_LENGTH: cfg_reg[0] <= pwdata[CB-1:0];
                fms_pkg::REG_WIDTH:  cfg_reg[1] <= pwdata[CB-1:0];
                fms_pkg::REG_HEIGHT: cfg_reg[2] <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fms_pkg::REG_LENGTH: prdata = 32'(cfg_reg[0]);
            fms_pkg::REG_WIDTH:  prdata = 32'(cfg_reg[1]);
            fms_pkg::REG_HEIGHT: prdata = 32'(cfg_reg[2]);
            default:             prdata = 32'd0;
        endcase
    end

    // tables
    fms_ram #(.DEPTH(MAXE), .WIDTH(fms_pkg::ENTRY_W)) u_tab0 (
        .aclk(aclk), .wr_en(wr_en && !wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd0)
    );
    fms_ram #(.DEPTH(MAXE), .WIDTH(fms_pkg::ENTRY_W)) u_tab1 (
        .aclk(aclk), .wr_en(wr_en && wr_bank), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd1)
    );

    assign rd_data = cur_reg ? rd1 : rd0;
    assign rd_addr = (state_reg == fms_pkg::S_P4_JRD) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];

    fms_rank u_rank (
        .aclk(aclk), .aresetn(aresetn), .feed(state_reg == fms_pkg::S_BST_US),
        .first(i_reg == '0), .ent(rd_data), .cfg(cfg_reg), .best(rank_best)
    );

    // geometry
    always_comb begin
        logic [1:0]  a;
        logic [1:0]  kr;
        logic [CB:0] b0, b1, r0, r1;
        boot_ent = '0;
        boot_ent.ext = cfg_reg;
        match = (rd_data == sp_reg);
        kr = k_reg[1:0];
        rem_ok = sp_reg.ext[kr] > bx_reg[kr];
        rem_val = sp_reg;
        rem_val.org[kr] = sp_reg.org[kr] + bx_reg[kr];
        rem_val.ext[kr] = sp_reg.ext[kr] - bx_reg[kr];
        hit = 1'b1;
        for (int x = 0; x < 3; x++) begin
            if (!(({1'b0, rd_data.org[x]} < ({1'b0, sp_reg.org[x]} + {1'b0, bx_reg[x]})) &&
                  (({1'b0, rd_data.org[x]} + {1'b0, rd_data.ext[x]}) > {1'b0, sp_reg.org[x]})))
                hit = 1'b0;
        end
        a  = k_reg[2:1];
        b0 = {1'b0, sp_reg.org[a]};
        b1 = {1'b0, sp_reg.org[a]} + {1'b0, bx_reg[a]};
        r0 = {1'b0, ent_reg.org[a]};
        r1 = {1'b0, ent_reg.org[a]} + {1'b0, ent_reg.ext[a]};
        piece_val = ent_reg;
        if (!k_reg[0]) begin
            piece_ok = r0 < b0;
            piece_val.ext[a] = CB'(b0 - r0);
        end else begin
            piece_ok = r1 > b1;
            piece_val.org[a] = b1[CB-1:0];
            piece_val.ext[a] = CB'(r1 - b1);
        end
        strict = inside_of(ent_reg, rd_data) && !inside_of(rd_data, ent_reg);
    end

    // table write selection
    always_comb begin
        put_req = 1'b0;
        put_val = rd_data;
        dir_wr  = 1'b0;
        dir_val = rd_data;
        wr_bank = !cur_reg;
        wr_addr = n_reg[IDX_W-1:0];
        case (state_reg)
            fms_pkg::S_BOOT: begin
                dir_wr  = 1'b1;
                dir_val = boot_ent;
                wr_bank = cur_reg;
                wr_addr = '0;
            end
            fms_pkg::S_IDLE: begin
                if (s_tvalid && (s_tuser == fms_pkg::OP_CLEAR)) begin
                    dir_wr  = 1'b1;
                    dir_val = boot_ent;
                    wr_bank = cur_reg;
                    wr_addr = '0;
                end
            end
            fms_pkg::S_P1_US:  put_req = !match;
            fms_pkg::S_P1_REM: begin
                put_req = rem_ok;
                put_val = rem_val;
            end
            fms_pkg::S_P2_US:  put_req = !hit;
            fms_pkg::S_P2_SPL: begin
                put_req = piece_ok;
                put_val = piece_val;
            end
            fms_pkg::S_P5_US:  dir_wr = 1'b1;
            default: ;
        endcase
    end

    assign full    = (n_reg == CNT_W'(MAXE));
    assign wr_en   = dir_wr || (put_req && !full);
    assign wr_data = dir_wr ? dir_val : put_val;
    assign n_inc   = n_reg + CNT_W'(wr_en);

    assign found    = (cnt_reg != '0);
    assign best_out = found ? rank_best : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fms_pkg::S_BOOT: state_next = fms_pkg::S_IDLE;
            fms_pkg::S_IDLE: begin
                if (s_tvalid)
                    state_next = (s_tuser == fms_pkg::OP_CLEAR) ? fms_pkg::S_BST_RD
                                                                : fms_pkg::S_P1_RD;
            end
            fms_pkg::S_P1_RD:
                state_next = (i_reg == cnt_reg) ? fms_pkg::S_P1_REM : fms_pkg::S_P1_US;
            fms_pkg::S_P1_US: state_next = fms_pkg::S_P1_RD;
            fms_pkg::S_P1_REM: begin
                if (k_reg == 3'd2) state_next = fms_pkg::S_P2_RD;
            end
            fms_pkg::S_P2_RD:
                state_next = (i_reg == cnt_reg) ? fms_pkg::S_P4_IRD : fms_pkg::S_P2_US;
            fms_pkg::S_P2_US: state_next = hit ? fms_pkg::S_P2_SPL : fms_pkg::S_P2_RD;
            fms_pkg::S_P2_SPL: begin
                if (k_reg == 3'd5) state_next = fms_pkg::S_P2_RD;
            end
            fms_pkg::S_P4_IRD: begin
                if (i_reg == cnt_reg) state_next = fms_pkg::S_P5_RD;
                else if (!drop_reg[i_reg[IDX_W-1:0]]) state_next = fms_pkg::S_P4_IUS;
            end
            fms_pkg::S_P4_IUS: state_next = fms_pkg::S_P4_JRD;
            fms_pkg::S_P4_JRD: begin
                if (j_reg == cnt_reg) state_next = fms_pkg::S_P4_IRD;
                else if ((j_reg != i_reg) && !drop_reg[j_reg[IDX_W-1:0]])
                    state_next = fms_pkg::S_P4_JUS;
            end
            fms_pkg::S_P4_JUS: state_next = strict ? fms_pkg::S_P4_IRD : fms_pkg::S_P4_JRD;
            fms_pkg::S_P5_RD: begin
                if (i_reg == cnt_reg) state_next = fms_pkg::S_BST_RD;
                else if (!drop_reg[i_reg[IDX_W-1:0]]) state_next = fms_pkg::S_P5_US;
            end
            fms_pkg::S_P5_US: state_next = fms_pkg::S_P5_RD;
            fms_pkg::S_BST_RD:
                state_next = (i_reg == cnt_reg) ? fms_pkg::S_DONE : fms_pkg::S_BST_US;
            fms_pkg::S_BST_US: state_next = fms_pkg::S_BST_W1;
            fms_pkg::S_BST_W1: state_next = fms_pkg::S_BST_W2;
            fms_pkg::S_BST_W2: state_next = fms_pkg::S_BST_RD;
            fms_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = fms_pkg::S_IDLE;
            end
            default: state_next = fms_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        sp_next   = sp_reg;
        bx_next   = bx_reg;
        ent_next  = ent_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        n_next    = n_inc;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        ovf_next  = ovf_reg || (put_req && full);
        drop_next = drop_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            fms_pkg::S_BOOT: cnt_next = CNT_W'(1);
            fms_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    for (int a = 0; a < 3; a++) begin
                        sp_next.org[a] = s_tdata[CB*a +: CB];
                        sp_next.ext[a] = s_tdata[CB*(a+3) +: CB];
                        bx_next[a]     = s_tdata[CB*(a+6) +: CB];
                    end
                    ovf_next = 1'b0;
                    i_next   = '0;
                    n_next   = '0;
                    if (s_tuser == fms_pkg::OP_CLEAR) cnt_next = CNT_W'(1);
                end
            end
            fms_pkg::S_P1_RD: k_next = '0;
            fms_pkg::S_P1_US: i_next = i_reg + 1'b1;
            fms_pkg::S_P1_REM: begin
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd2) begin
                    cur_next = !cur_reg;
                    cnt_next = n_inc;
                    n_next   = '0;
                    i_next   = '0;
                end
            end
            fms_pkg::S_P2_RD: begin
                if (i_reg == cnt_reg) begin
                    cur_next  = !cur_reg;
                    cnt_next  = n_reg;
                    n_next    = '0;
                    i_next    = '0;
                    drop_next = '0;
                end
            end
            fms_pkg::S_P2_US: begin
                ent_next = rd_data;
                k_next   = '0;
                if (!hit) i_next = i_reg + 1'b1;
            end
            fms_pkg::S_P2_SPL: begin
                k_next = k_reg + 1'b1;
                if (k_reg == 3'd5) i_next = i_reg + 1'b1;
            end
            fms_pkg::S_P4_IRD: begin
                if (i_reg == cnt_reg) begin
                    i_next = '0;
                    n_next = '0;
                end else if (drop_reg[i_reg[IDX_W-1:0]]) begin
                    i_next = i_reg + 1'b1;
                end
            end
            fms_pkg::S_P4_IUS: begin
                ent_next = rd_data;
                j_next   = '0;
            end
            fms_pkg::S_P4_JRD: begin
                if (j_reg == cnt_reg) i_next = i_reg + 1'b1;
                else if ((j_reg == i_reg) || drop_reg[j_reg[IDX_W-1:0]]) j_next = j_reg + 1'b1;
            end
            fms_pkg::S_P4_JUS: begin
                if (strict) begin
                    drop_next[i_reg[IDX_W-1:0]] = 1'b1;
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            fms_pkg::S_P5_RD: begin
                if (i_reg == cnt_reg) begin
                    cur_next = !cur_reg;
                    cnt_next = n_reg;
                    i_next   = '0;
                end else if (drop_reg[i_reg[IDX_W-1:0]]) begin
                    i_next = i_reg + 1'b1;
                end
            end
            fms_pkg::S_P5_US:  i_next = i_reg + 1'b1;
            fms_pkg::S_BST_W2: i_next = i_reg + 1'b1;
            fms_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = fms_pkg::OUT_DATA_W'({cnt_reg, best_out.ext, best_out.org});
                    m_tuser_next  = {ovf_reg, found};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fms_pkg::S_BOOT;
            i_reg        <= '0;
            j_reg        <= '0;
            n_reg        <= '0;
            k_reg        <= '0;
            cnt_reg      <= CNT_W'(1);
            cur_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            drop_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            n_reg        <= n_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            cur_reg      <= cur_next;
            ovf_reg      <= ovf_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sp_reg      <= sp_next;
        bx_reg      <= bx_next;
        ent_reg     <= ent_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == fms_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- hw/rtl/fms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fms_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 72
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/fms_rank.sv -----
// Best-entry ranking unit: corner distance, two-step volume product, running best.
// Depends on fms_pkg.
module fms_rank (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    feed,
    input  logic                                    first,
    input  fms_pkg::entry_t                         ent,
    input  logic [2:0][fms_pkg::COORD_BITS-1:0]     cfg,
    output fms_pkg::entry_t                         best
);

    localparam int CB = fms_pkg::COORD_BITS;

    logic                          s1_valid_reg, s2_valid_reg;
    logic                          s1_first_reg, s2_first_reg;
    fms_pkg::entry_t               s1_ent_reg, s2_ent_reg, best_reg;
    logic [fms_pkg::DIST_W-1:0]    s1_dist_reg, s2_dist_reg, bd_reg;
    logic [2*CB-1:0]               s1_prod_reg;
    logic [fms_pkg::VOL_W-1:0]     s2_vol_reg, bv_reg;
    logic [fms_pkg::DIST_W-1:0]    cdist;
    logic                          better;

    always_comb begin
        logic [CB:0] top;
        logic [CB:0] hi;
        logic [CB:0] lo;
        cdist = '0;
        for (int a = 0; a < 3; a++) begin
            top = {1'b0, ent.org[a]} + {1'b0, ent.ext[a]};
            hi  = (top >= {1'b0, cfg[a]}) ? top - {1'b0, cfg[a]} : {1'b0, cfg[a]} - top;
            lo  = {1'b0, ent.org[a]};
            cdist = cdist + fms_pkg::DIST_W'((lo < hi) ? lo : hi);
        end
    end

    assign better = s2_first_reg || (s2_dist_reg < bd_reg) ||
                    ((s2_dist_reg == bd_reg) && (s2_vol_reg > bv_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= feed;
            s2_valid_reg <= s1_valid_reg;
        end
        s1_first_reg <= first;
        s1_ent_reg   <= ent;
        s1_dist_reg  <= cdist;
        s1_prod_reg  <= ent.ext[0] * ent.ext[1];
        s2_first_reg <= s1_first_reg;
        s2_ent_reg   <= s1_ent_reg;
        s2_dist_reg  <= s1_dist_reg;
        s2_vol_reg   <= s1_prod_reg * s1_ent_reg.ext[2];
        if (s2_valid_reg && better) begin
            best_reg <= s2_ent_reg;
            bd_reg   <= s2_dist_reg;
            bv_reg   <= s2_vol_reg;
        end
    end

    assign best = best_reg;

endmodule

// ----- hw/rtl/fms_checker.sv -----
// Port-level checker for the free space manager core, bound to the top level.
// Depends on fms_pkg and maximal_free_space_manager_core.
module fms_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fms_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [1:0]                        m_tuser
);

    localparam int BW = 6 * fms_pkg::COORD_BITS;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    a_found_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tdata[BW +: fms_pkg::CNT_W] != '0)))
        else $error("found flag disagrees with entry count");

    a_empty_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[BW-1:0] == '0))
        else $error("empty table reports nonzero cuboid");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[BW +: fms_pkg::CNT_W] <= fms_pkg::CNT_W'(fms_pkg::MAX_ENTRIES)))
        else $error("entry count beyond table depth");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled output item changed");

endmodule

bind maximal_free_space_manager_core fms_checker u_fms_checker (.*);

// ----- sim/maximal_free_space_manager_core_tb.sv -----
// Testbench for maximal_free_space_manager_core: random and directed clear/place items,
// checked against an in-bench free space table predictor. Depends on fms_pkg and the core RTL.
`timescale 1ns / 100ps

module maximal_free_space_manager_core_tb;

    localparam int COORD_BITS  = fms_pkg::COORD_BITS;
    localparam int MAX_ENTRIES = fms_pkg::MAX_ENTRIES;
    localparam int IN_DATA_W   = fms_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = fms_pkg::OUT_DATA_W;
    localparam int PADDR_W     = fms_pkg::PADDR_W;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        logic      op;
        logic [8:0][COORD_BITS-1:0] f;
    } item_t;

    typedef struct packed {
        logic found;
        logic [5:0][COORD_BITS-1:0] box;
        logic [6:0] cnt;
        logic ovf;
    } best_t;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, s_tuser;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid, m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    maximal_free_space_manager_core dut (.*);

    // free space table predictor
    longint ftab[MAX_ENTRIES][6];
    longint stage[MAX_ENTRIES][6];
    longint tmp[6], sp[6], bx[3];
    bit     drop[MAX_ENTRIES];
    int     fcount, nstage;
    bit     spill;
    longint cfg_ext[3];

    item_t item_q[$];
    best_t best_q[$];
    best_t inflight_best, best_wait[$];
    int    errs;
    bit    calm;
    longint cycles;
    string box_name[6] = '{"best_x", "best_y", "best_z", "best_len", "best_wid", "best_hgt"};

    function automatic void stage_put();
        if (nstage >= MAX_ENTRIES) begin
            spill = 1;
            return;
        end
        for (int k = 0; k < 6; k++) stage[nstage][k] = tmp[k] & 64'hFFF;
        nstage++;
    endfunction

    function automatic void take_stage();
        for (int i = 0; i < nstage; i++)
            for (int k = 0; k < 6; k++) ftab[i][k] = stage[i][k];
        fcount = nstage;
    endfunction

    function automatic bit contained(int i, int j);
        for (int a = 0; a < 3; a++) begin
            if (ftab[i][a] < ftab[j][a]) return 0;
            if (ftab[i][a] + ftab[i][a+3] > ftab[j][a] + ftab[j][a+3]) return 0;
        end
        return 1;
    endfunction

    function automatic longint corner_dist(int i);
        longint sum, lo, hi;
        sum = 0;
        for (int a = 0; a < 3; a++) begin
            lo = ftab[i][a];
            hi = ftab[i][a] + ftab[i][a+3] - cfg_ext[a];
            if (hi < 0) hi = -hi;
            sum += (lo < hi) ? lo : hi;
        end
        return sum;
    endfunction

    function automatic void place_block();
        bit same, hit;
        longint b0, b1, r0, r1;
        nstage = 0;
        for (int i = 0; i < fcount; i++) begin
            same = 1;
            for (int k = 0; k < 6; k++) if (ftab[i][k] != sp[k]) same = 0;
            if (!same) begin
                for (int k = 0; k < 6; k++) tmp[k] = ftab[i][k];
                stage_put();
            end
        end
        for (int a = 0; a < 3; a++) begin
            if (sp[a+3] > bx[a]) begin
                for (int k = 0; k < 6; k++) tmp[k] = sp[k];
                tmp[a] = sp[a] + bx[a];
                tmp[a+3] = sp[a+3] - bx[a];
                stage_put();
            end
        end
        take_stage();
        nstage = 0;
        for (int i = 0; i < fcount; i++) begin
            hit = 1;
            for (int a = 0; a < 3; a++)
                if (!(ftab[i][a] < sp[a] + bx[a] && ftab[i][a] + ftab[i][a+3] > sp[a]))
                    hit = 0;
            if (!hit) begin
                for (int k = 0; k < 6; k++) tmp[k] = ftab[i][k];
                stage_put();
                continue;
            end
            for (int a = 0; a < 3; a++) begin
                b0 = sp[a];
                b1 = sp[a] + bx[a];
                r0 = ftab[i][a];
                r1 = ftab[i][a] + ftab[i][a+3];
                if (r0 < b0) begin
                    for (int k = 0; k < 6; k++) tmp[k] = ftab[i][k];
                    tmp[a+3] = b0 - r0;
                    stage_put();
                end
                if (r1 > b1) begin
                    for (int k = 0; k < 6; k++) tmp[k] = ftab[i][k];
                    tmp[a] = b1;
                    tmp[a+3] = r1 - b1;
                    stage_put();
                end
            end
        end
        take_stage();
        for (int i = 0; i < fcount; i++) drop[i] = 0;
        for (int i = 0; i < fcount; i++) begin
            if (drop[i]) continue;
            for (int j = 0; j < fcount; j++) begin
                if (i == j || drop[j]) continue;
                if (contained(i, j) && !contained(j, i)) begin
                    drop[i] = 1;
                    break;
                end
            end
        end
        nstage = 0;
        for (int i = 0; i < fcount; i++) begin
            if (!drop[i]) begin
                for (int k = 0; k < 6; k++) stage[nstage][k] = ftab[i][k];
                nstage++;
            end
        end
        take_stage();
    endfunction

    function automatic best_t predict_best(item_t it);
        best_t r;
        int bi;
        longint bd, d, bv, vol;
        spill = 0;
        if (it.op == fms_pkg::OP_CLEAR) begin
            for (int a = 0; a < 3; a++) begin
                ftab[0][a] = 0;
                ftab[0][a+3] = cfg_ext[a];
            end
            fcount = 1;
        end else begin
            for (int k = 0; k < 6; k++) sp[k] = it.f[k];
            for (int k = 0; k < 3; k++) bx[k] = it.f[6+k];
            place_block();
        end
        r = '0;
        if (fcount > 0) begin
            bi = 0;
            bd = corner_dist(0);
            bv = ftab[0][3] * ftab[0][4] * ftab[0][5];
            for (int i = 1; i < fcount; i++) begin
                d = corner_dist(i);
                vol = ftab[i][3] * ftab[i][4] * ftab[i][5];
                if (d < bd || (d == bd && vol > bv)) begin
                    bi = i;
                    bd = d;
                    bv = vol;
                end
            end
            r.found = 1;
            for (int k = 0; k < 6; k++) r.box[k] = ftab[bi][k][COORD_BITS-1:0];
        end
        r.cnt = fcount[6:0];
        r.ovf = spill;
        return r;
    endfunction

    function automatic void send(item_t it);
        item_q = {item_q, it};
        best_q = {best_q, predict_best(it)};
    endfunction

    function automatic void send_clear();
        item_t it;
        it = '0;
        it.op = fms_pkg::OP_CLEAR;
        send(it);
    endfunction

    function automatic void send_place(longint s[6], longint b[3]);
        item_t it;
        it.op = fms_pkg::OP_PLACE;
        for (int k = 0; k < 6; k++) it.f[k] = s[k][COORD_BITS-1:0];
        for (int k = 0; k < 3; k++) it.f[6+k] = b[k][COORD_BITS-1:0];
        send(it);
    endfunction

    // place on a live entry (sometimes with a perturbed field), or noise
    function automatic void send_random();
        longint s[6], b[3];
        int idx, pick;
        item_t it;
        pick = $urandom_range(0, 99);
        if (fcount == 0 || pick < 12) begin
            it.op = ($urandom_range(0, 9) == 0) ? fms_pkg::OP_CLEAR : fms_pkg::OP_PLACE;
            for (int k = 0; k < 9; k++) it.f[k] = $urandom;
            send(it);
            return;
        end
        idx = $urandom_range(0, fcount - 1);
        for (int k = 0; k < 6; k++) s[k] = ftab[idx][k];
        for (int a = 0; a < 3; a++) begin
            if (pick < 20) b[a] = s[a+3];
            else b[a] = $urandom_range(0, int'(s[a+3]));
        end
        if (pick < 28) s[$urandom_range(0, 5)] += $urandom_range(1, 40);
        send_place(s, b);
    endfunction

    task automatic wait_idle();
        while (item_q.size() != 0 || s_tvalid || best_wait.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        cfg_ext[idx] = val & 32'hFFF;
    endtask

    task automatic set_container(longint l, longint w, longint h);
        wait_idle();
        write_reg(fms_pkg::REG_LENGTH, 32'(l));
        write_reg(fms_pkg::REG_WIDTH, 32'(w));
        write_reg(fms_pkg::REG_HEIGHT, 32'(h));
    endtask

    task automatic random_run(int n);
        send_clear();
        for (int i = 0; i < n; i++) begin
            if (fcount > 40 && $urandom_range(0, 1) == 0) send_clear();
            else send_random();
        end
    endtask

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        longint s[6], b[3];
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        m_tready = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        errs = 0;
        calm = 0;
        cfg_ext = '{1024, 1024, 1024};
        for (int k = 0; k < 6; k++) ftab[0][k] = (k < 3) ? 0 : 1024;
        fcount = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // directed
        s = '{0, 0, 0, 1024, 1024, 1024}; b = '{100, 200, 300};
        send_place(s, b);
        s = '{100, 0, 0, 924, 1024, 1024}; b = '{0, 0, 0};
        send_place(s, b);
        s = '{100, 0, 0, 924, 1024, 1024}; b = '{924, 1024, 1024};
        send_place(s, b);
        s = '{5, 5, 5, 10, 10, 10}; b = '{20, 20, 20};
        send_place(s, b);
        s = '{4095, 4095, 4095, 4095, 4095, 4095}; b = '{4095, 4095, 4095};
        send_place(s, b);
        s = '{0, 0, 0, 0, 0, 0}; b = '{0, 0, 0};
        send_place(s, b);
        send_clear();
        s = '{0, 0, 0, 1024, 1024, 1024}; b = '{1024, 1024, 1024};
        send_place(s, b);
        s = '{0, 0, 0, 1, 1, 1}; b = '{1, 1, 1};
        send_place(s, b);
        send_clear();
        for (int i = 0; i < 12; i++) begin
            s = '{$urandom_range(0, 1000), $urandom_range(0, 1000), $urandom_range(0, 1000),
                  8, 8, 8};
            b = '{$urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8)};
            send_place(s, b);
        end

        calm = 1;
        random_run(30);
        set_container(4095, 4095, 4095);
        calm = 0;
        send_clear();
        for (int i = 0; i < 10; i++) begin
            s = '{$urandom_range(0, 4000), $urandom_range(0, 4000), $urandom_range(0, 4000),
                  30, 30, 30};
            b = '{30, 30, 30};
            send_place(s, b);
        end
        random_run(15);
        set_container(1, 1, 1);
        random_run(15);
        set_container($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1, 4095));
        random_run(20);
        set_container(4095, 1, 2000);
        random_run(12);

        wait_idle();
        if (errs == 0) $display("maximal_free_space_manager_core_tb: PASS");
        else $display("maximal_free_space_manager_core_tb: FAIL");
        $finish;
    end

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) best_wait = {best_wait, inflight_best};
            if (!s_tvalid || s_tready) begin
                if (item_q.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                    s_tvalid <= 1;
                    s_tuser <= item_q[0].op;
                    s_tdata <= IN_DATA_W'(item_q[0].f);
                    inflight_best = best_q.pop_front();
                    void'(item_q.pop_front());
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        best_t e;
        if (!aresetn) begin
            m_tready <= 0;
            cycles <= 0;
        end else begin
            cycles <= cycles + 1;
            m_tready <= calm || ($urandom_range(0, 99) >= 12);
            if (m_tvalid && m_tready) begin
                if (best_wait.size() == 0) begin
                    $error("unexpected result item");
                    errs++;
                end else begin
                    e = best_wait.pop_front();
                    if (m_tuser[0] !== e.found) begin
                        $error("found exp %0d got %0d", e.found, m_tuser[0]); errs++;
                    end
                    if (m_tuser[1] !== e.ovf) begin
                        $error("overflow exp %0d got %0d", e.ovf, m_tuser[1]); errs++;
                    end
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[k*COORD_BITS +: COORD_BITS] !== e.box[k]) begin
                            $error("%s exp %0d got %0d",
                                   box_name[k], e.box[k], m_tdata[k*COORD_BITS +: COORD_BITS]);
                            errs++;
                        end
                    if (m_tdata[6*COORD_BITS +: 7] !== e.cnt) begin
                        $error("entry_count exp %0d got %0d", e.cnt, m_tdata[6*COORD_BITS +: 7]);
                        errs++;
                    end
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("maximal_free_space_manager_core_tb: FAIL");
                $finish;
            end
        end
    end

endmodule
